// ===== sv/pli_pkg.sv =====
// Shared types, constants and helpers for the positional list block.
package pli_pkg;

  // List geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths
  localparam int CMD_W   = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 5;
  localparam int STAT_W  = 3;
  localparam int FIDX_W  = 4;
  localparam int COUNT_W = 5;
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Commands
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  // Cell operations
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;

  // Broadcast to every cell of the chain
  typedef struct packed {
    logic [1:0]         op;
    logic [IDX_W-1:0]   idx;
    logic [VALUE_W-1:0] value;
  } cell_ctl_t;

  // Result fields waiting for the search encode
  typedef struct packed {
    logic               search;
    logic [STAT_W-1:0]  status;
    logic [CNT_W-1:0]   count;
  } pend_t;

  // Lowest set bit of the match vector
  function automatic logic [IDX_W-1:0] first_hit(input logic [CAPACITY-1:0] m);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (m[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

endpackage

// ===== sv/positional_list_insert_remove_search.sv =====
// Top level: fixed-capacity ordered list built as a chain of shifting cells.
// A command's fields wait in pend_r, then load the output beat once it is free.
// Throughput: one command per cycle unless out_ready stalls a pending result; every
// cell shifts and compares on accept, and the result stage encodes the first search
// hit over the cell match bits. Reset: synchronous active-low rst_n empties the list
// and drops both valid flags; cell contents are not cleared.
module positional_list_insert_remove_search (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pli_pkg::CMD_W-1:0]     in_command,
  input  logic signed [pli_pkg::VALUE_W-1:0] in_value,
  input  logic [pli_pkg::POS_W-1:0]     in_position,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pli_pkg::STAT_W-1:0]    out_status,
  output logic [pli_pkg::FIDX_W-1:0]    out_found_index,
  output logic [pli_pkg::COUNT_W-1:0]   out_count
);
  import pli_pkg::*;

  logic               accept;
  logic               take;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CMP_W-1:0]   pos_ext, cnt_ext;
  logic               pos_ok;
  logic               full;
  cell_ctl_t          ctl;
  pend_t              pend;
  logic [CAPACITY-1:0] live;
  logic [CAPACITY-1:0] match;
  logic [VALUE_W-1:0] data [CAPACITY];

  assign in_ready = take;
  assign accept   = in_valid && take;

  assign pos_ext = CMP_W'(in_position);
  assign cnt_ext = CMP_W'(count_r);
  assign pos_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign full    = (count_r == CNT_W'(CAPACITY));

  // Command decode against the current fill count
  always_comb begin
    ctl.op      = OP_HOLD;
    ctl.idx     = IDX_W'(pos_ext - CMP_W'(1));
    ctl.value   = in_value;
    count_nxt   = count_r;
    pend.search = 1'b0;
    pend.status = ST_OK;
    unique case (in_command)
      CMD_APPEND: begin
        if (full) pend.status = ST_FULL;
        else begin
          ctl.op    = OP_INS;
          ctl.idx   = IDX_W'(count_r);
          count_nxt = CNT_W'(count_r + 1'b1);
        end
      end
      CMD_INSERT: begin
        if (full) pend.status = ST_FULL;
        else if (!pos_ok) pend.status = ST_BADPOS;
        else begin
          ctl.op    = OP_INS;
          count_nxt = CNT_W'(count_r + 1'b1);
        end
      end
      CMD_REMOVE: begin
        if (count_r == '0) pend.status = ST_EMPTY;
        else if (!pos_ok) pend.status = ST_BADPOS;
        else begin
          ctl.op    = OP_DEL;
          count_nxt = CNT_W'(count_r - 1'b1);
        end
      end
      CMD_SEARCH: pend.search = 1'b1;
      CMD_CLEAR: begin
        if (count_r == '0) pend.status = ST_EMPTY;
        else count_nxt = '0;
      end
      default: pend.status = ST_OK;
    endcase
    pend.count = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else if (accept) count_r <= count_nxt;
  end

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_W-1:0] left_d, right_d;
    assign live[i] = (CNT_W'(i) < count_r);
    if (i == 0) begin : g_head
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = data[i+1];
    end
    pli_cell u_cell (
      .clk        (clk),
      .en         (accept),
      .cell_idx   (IDX_W'(i)),
      .live       (live[i]),
      .ctl        (ctl),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (data[i]),
      .match      (match[i])
    );
  end

  pli_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (accept),
    .pend_in         (pend),
    .match           (match),
    .take            (take),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_count       (out_count)
  );

endmodule

// ===== sv/pli_cell.sv =====
// One list slot: holds a word, shifts with its neighbors, compares against the key.
module pli_cell (
  input  logic                      clk,
  input  logic                      en,
  input  logic [pli_pkg::IDX_W-1:0] cell_idx,
  input  logic                      live,
  input  pli_pkg::cell_ctl_t        ctl,
  input  logic [pli_pkg::VALUE_W-1:0] left_data,
  input  logic [pli_pkg::VALUE_W-1:0] right_data,
  output logic [pli_pkg::VALUE_W-1:0] data,
  output logic                      match
);
  import pli_pkg::*;

  logic [VALUE_W-1:0] data_r, data_nxt;
  logic               match_r, match_nxt;

  // Shift toward the tail on insert, toward the head on remove
  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      OP_INS: begin
        if (cell_idx > ctl.idx)       data_nxt = left_data;
        else if (cell_idx == ctl.idx) data_nxt = ctl.value;
      end
      OP_DEL: begin
        if (cell_idx >= ctl.idx) data_nxt = right_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  // Key compare on the current contents
  assign match_nxt = live && (data_r == ctl.value);

  always_ff @(posedge clk) begin
    if (en) begin
      data_r  <= data_nxt;
      match_r <= match_nxt;
    end
  end

  assign data  = data_r;
  assign match = match_r;

endmodule

// ===== sv/pli_out.sv =====
// Result stage: finishes the search encode and holds the output beat.
module pli_out (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  pli_pkg::pend_t                pend_in,
  input  logic [pli_pkg::CAPACITY-1:0]  match,
  output logic                          take,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pli_pkg::STAT_W-1:0]    out_status,
  output logic [pli_pkg::FIDX_W-1:0]    out_found_index,
  output logic [pli_pkg::COUNT_W-1:0]   out_count
);
  import pli_pkg::*;

  pend_t              pend_r;
  logic               pend_valid_r;
  logic               out_valid_r;
  logic               out_load;
  logic               hit;
  logic [STAT_W-1:0]  status_r, status_nxt;
  logic [FIDX_W-1:0]  found_r, found_nxt;
  logic [COUNT_W-1:0] count_r;

  assign out_load = pend_valid_r && (!out_valid_r || out_ready);
  assign take     = !pend_valid_r || out_load;

  // Pending stage and output beat handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (load)          pend_valid_r <= 1'b1;
      else if (out_load) pend_valid_r <= 1'b0;
      if (out_load)                 out_valid_r <= 1'b1;
      else if (out_ready)           out_valid_r <= 1'b0;
    end
  end

  // Search outcome from the cell match bits; other commands pass their status through
  always_comb begin
    hit        = |match;
    status_nxt = pend_r.status;
    found_nxt  = '0;
    if (pend_r.search) begin
      status_nxt = hit ? ST_OK : ST_NOTFOUND;
      if (hit) found_nxt = FIDX_W'(first_hit(match));
    end
  end

  always_ff @(posedge clk) begin
    if (load) pend_r <= pend_in;
    if (out_load) begin
      status_r <= status_nxt;
      found_r  <= found_nxt;
      count_r  <= COUNT_W'(pend_r.count);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_found_index = found_r;
  assign out_count       = count_r;

endmodule

// ===== sv/pli_check.sv =====
// Port-level checker for the positional list, bound to the top level.
module pli_check (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pli_pkg::STAT_W-1:0]    out_status,
  input logic [pli_pkg::FIDX_W-1:0]    out_found_index,
  input logic [pli_pkg::COUNT_W-1:0]   out_count
);
  import pli_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_found_index) && $stable(out_count))
    else $error("result beat changed while stalled");

  // Fill never exceeds capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= COUNT_W'(CAPACITY)))
    else $error("count above capacity");

  // Full and empty reports agree with the count
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (out_count == COUNT_W'(CAPACITY)))
    else $error("full status with list not full");

  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> (out_count == '0))
    else $error("empty status with entries present");

  // A nonzero hit index only comes with ok status and lies within the list
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_found_index != '0) |->
      (out_status == ST_OK) && (COUNT_W'(out_found_index) < out_count))
    else $error("found index without a valid hit");

endmodule

bind positional_list_insert_remove_search pli_check u_pli_check (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_found_index (out_found_index),
  .out_count       (out_count)
);
